FILE: hw/rtl/srin_pkg.sv
// srin_pkg: shared types and constants of the sorted ring neighbor table
// word formats of both channels, the stored node entry and cell flags
// no dependencies
`default_nettype none

package srin_pkg;

  localparam int ID_W   = 10;
  localparam int ADDR_W = 32;
  localparam int PORT_W = 16;
  localparam int STAT_W = 2;

  localparam logic [STAT_W-1:0] STAT_INSERTED = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] STAT_DUP      = 2'd2;

  // one ring node as held in a cell
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [ADDR_W-1:0] addr;
    logic [PORT_W-1:0] port;
  } node_t;

  localparam int NODE_W = $bits(node_t);

  typedef struct packed {
    logic [ID_W-1:0]   new_id;
    logic [ADDR_W-1:0] new_addr;
    logic [PORT_W-1:0] new_port;
  } in_word_t;

  typedef struct packed {
    logic [ID_W-1:0]   target_id;
    logic [ADDR_W-1:0] target_addr;
    logic [PORT_W-1:0] target_port;
    logic [ID_W-1:0]   succ_id;
    logic [ADDR_W-1:0] succ_addr;
    logic [PORT_W-1:0] succ_port;
    logic [ID_W-1:0]   pred_id;
    logic [ADDR_W-1:0] pred_addr;
    logic [PORT_W-1:0] pred_port;
    logic [STAT_W-1:0] status;
    logic              last;
  } out_word_t;

  // compare flags a cell reports to the row
  typedef struct packed {
    logic lt;  // live entry below the new identifier
    logic eq;  // live entry equal to the new identifier
  } cell_flags_t;

endpackage

`default_nettype wire

FILE: hw/rtl/srin_cell.sv
// srin_cell: one slot of the sorted node row
// compares its entry with the new node and keeps, loads or shifts in
// depends on srin_pkg
`default_nettype none

module srin_cell (
  input  wire                  clk,
  input  wire                  ins,        // insert strobe for the whole row
  input  wire                  live,       // slot index below node count
  input  wire                  prev_lt,    // left neighbor lies below new node
  input  srin_pkg::node_t      new_node,
  input  srin_pkg::node_t      prev_node,  // entry of the left neighbor
  output srin_pkg::node_t      node,
  output srin_pkg::cell_flags_t flags
);

  assign flags.lt = live && (node.id < new_node.id);
  assign flags.eq = live && (node.id == new_node.id);

  // entries below the new node stay, the slot at the boundary takes it,
  // everything above moves up one place
  always_ff @(posedge clk) begin
    if (ins && !flags.lt) begin
      if (prev_lt) begin
        node <= new_node;
      end else begin
        node <= prev_node;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/sorted_ring_insert_neighbors.sv
// sorted_ring_insert_neighbors: top level of the sorted ring neighbor table
// row of srin_cell slots, neighbor selection, result sequencer, output register
// depends on srin_pkg and srin_cell
//
// usage
//   in channel: one word per node join (id, ipv4 address, port), taken when
//   in_valid is high and in_stall low. in_stall is high from the word's
//   acceptance until its last result has been loaded into the output register.
//   out channel: one to three result words per input, in order: the new node
//   with its ring successor and predecessor, then the predecessor notice,
//   then the successor notice; notices to self_id are dropped. last marks
//   the final word of an input. duplicate id or full table gives one word.
//   cfg: self_id written on any edge with cfg_we high; write it while idle.
// sequence
//   per input word: a capture step, then an evaluate step in which every cell
//   compares and shifts in parallel while the neighbor entries are picked,
//   then the result words one at a time through the single output register.
//   a stalled receiver holds the output register and with it the sequencer;
//   a new input is taken while the final result still waits.
// reset
//   synchronous rst empties the table (count zero), clears self_id, drops
//   any pending result; entry contents are not cleared, only counted.
`default_nettype none

module sorted_ring_insert_neighbors #(
  parameter int MAX_PEERS = 16
) (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       in_valid,
  output logic                      in_stall,
  input  srin_pkg::in_word_t        in_word,
  output logic                      out_valid,
  input  wire                       out_stall,
  output srin_pkg::out_word_t       out_word,
  input  wire                       cfg_we,
  input  wire [srin_pkg::ID_W-1:0]  cfg_data
);

  localparam int N  = MAX_PEERS;
  localparam int CW = $clog2(MAX_PEERS + 1);
  localparam int NW = srin_pkg::NODE_W;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EVAL = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t state, state_next;

  logic [srin_pkg::ID_W-1:0] self_id;
  logic [CW-1:0]             node_count;
  logic [CW-1:0]             count_old;   // count before the current insert
  srin_pkg::node_t           new_node;
  logic                      dup_r, full_r;
  logic [2:0]                pend, pend_next;

  // neighbor entries picked before the shift
  srin_pkg::node_t p1_r, p2_r, s1_r, s2_r;

  // ---------------------------------------------------------------
  // cell row
  // ---------------------------------------------------------------
  srin_pkg::node_t       cell_node  [N];
  srin_pkg::cell_flags_t cell_flags [N];
  logic [N-1:0]          lt_v, eq_v, live_v, lt_prev;
  logic                  ins;

  assign lt_prev = {lt_v[N-2:0], 1'b1};

  for (genvar i = 0; i < N; i++) begin : g_cell
    srin_pkg::node_t prev_node;
    if (i == 0) begin : g_first
      assign prev_node = new_node;
    end else begin : g_rest
      assign prev_node = cell_node[i-1];
    end

    assign live_v[i] = node_count > CW'(i);
    assign lt_v[i]   = cell_flags[i].lt;
    assign eq_v[i]   = cell_flags[i].eq;

    srin_cell u_cell (
      .clk       (clk),
      .ins       (ins),
      .live      (live_v[i]),
      .prev_lt   (lt_prev[i]),
      .new_node  (new_node),
      .prev_node (prev_node),
      .node      (cell_node[i]),
      .flags     (cell_flags[i])
    );
  end

  // ---------------------------------------------------------------
  // neighbor selection, one-hot over the slots
  // ---------------------------------------------------------------
  logic         dup_c, full_c, any_lt, any_bound;
  logic [N-1:0] lt_next, live_next, last_live, bound;
  logic [N-1:0] sel_p1, sel_p2, sel_s1, sel_s2;

  assign dup_c     = |eq_v;
  assign full_c    = node_count == CW'(MAX_PEERS);
  assign lt_next   = {1'b0, lt_v[N-1:1]};
  assign live_next = {1'b0, live_v[N-1:1]};
  assign last_live = live_v & ~live_next;
  // first live slot not below the new node
  assign bound     = live_v & ~lt_v & lt_prev;
  assign any_lt    = |lt_v;
  assign any_bound = |bound;

  // predecessor: last slot below the new node, else wrap to the top entry
  assign sel_p1 = (lt_v & ~lt_next) | (last_live & {N{~any_lt}});
  // successor: boundary slot, else wrap to slot zero
  assign sel_s1 = bound | {{(N-1){1'b0}}, ~any_bound};
  // one step further around the ring
  assign sel_p2 = {1'b0, sel_p1[N-1:1]} | (last_live & {N{sel_p1[0]}});
  assign sel_s2 = ({sel_s1[N-2:0], 1'b0} & live_v) |
                  {{(N-1){1'b0}}, |(sel_s1 & last_live)};

  logic [NW-1:0] acc_p1, acc_p2, acc_s1, acc_s2;

  always_comb begin
    acc_p1 = '0;
    acc_p2 = '0;
    acc_s1 = '0;
    acc_s2 = '0;
    for (int i = 0; i < N; i++) begin
      acc_p1 = acc_p1 | (cell_node[i] & {NW{sel_p1[i]}});
      acc_p2 = acc_p2 | (cell_node[i] & {NW{sel_p2[i]}});
      acc_s1 = acc_s1 | (cell_node[i] & {NW{sel_s1[i]}});
      acc_s2 = acc_s2 | (cell_node[i] & {NW{sel_s2[i]}});
    end
  end

  // ---------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------
  logic          out_load;
  logic [2:0]    pick;
  logic          notify_pred, notify_succ;
  srin_pkg::node_t p1_c, s1_c;

  assign p1_c = srin_pkg::node_t'(acc_p1);
  assign s1_c = srin_pkg::node_t'(acc_s1);

  assign in_stall = state != ST_IDLE;
  assign ins      = (state == ST_EVAL) && !dup_c && !full_c;

  assign notify_pred = (node_count != '0) && (p1_c.id != self_id);
  assign notify_succ = (node_count > CW'(1)) && (s1_c.id != self_id);

  assign out_load = (state == ST_EMIT) && (pend != '0) && (!out_valid || !out_stall);

  // lowest pending result goes first
  always_comb begin
    priority if (pend[0]) begin
      pick = 3'b001;
    end else if (pend[1]) begin
      pick = 3'b010;
    end else begin
      pick = 3'b100;
    end
  end

  always_comb begin
    state_next = state;
    pend_next  = pend;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        state_next = ST_EMIT;
        if (dup_c || full_c) begin
          pend_next = 3'b001;
        end else begin
          pend_next = {notify_succ, notify_pred, 1'b1};
        end
      end
      ST_EMIT: begin
        if (out_load) begin
          pend_next = pend & ~pick;
          if ((pend & ~pick) == '0) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
        pend_next  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      pend       <= '0;
      node_count <= '0;
      self_id    <= '0;
    end else begin
      state <= state_next;
      pend  <= pend_next;
      if (ins) begin
        node_count <= node_count + CW'(1);
      end
      if (cfg_we) begin
        self_id <= cfg_data;
      end
    end
  end

  // payload captures
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      new_node.id   <= in_word.new_id;
      new_node.addr <= in_word.new_addr;
      new_node.port <= in_word.new_port;
    end
    if (state == ST_EVAL) begin
      dup_r     <= dup_c;
      full_r    <= full_c;
      count_old <= node_count;
      p1_r      <= p1_c;
      p2_r      <= srin_pkg::node_t'(acc_p2);
      s1_r      <= s1_c;
      s2_r      <= srin_pkg::node_t'(acc_s2);
    end
  end

  // ---------------------------------------------------------------
  // result word build and output register
  // ---------------------------------------------------------------
  srin_pkg::node_t     tgt_n, suc_n, pre_n;
  srin_pkg::out_word_t word_c;

  always_comb begin
    tgt_n = new_node;
    suc_n = s1_r;
    pre_n = p1_r;
    unique case (pick)
      3'b001: begin
        if (dup_r || full_r) begin
          suc_n = '0;
          pre_n = '0;
        end else if (count_old == '0) begin
          // alone on the ring
          suc_n = new_node;
          pre_n = new_node;
        end
      end
      3'b010: begin
        tgt_n = p1_r;
        suc_n = new_node;
        // with two nodes the other one sees the new node on both sides
        pre_n = (count_old == CW'(1)) ? new_node : p2_r;
      end
      3'b100: begin
        tgt_n = s1_r;
        suc_n = s2_r;
        pre_n = new_node;
      end
      default: begin
        tgt_n = new_node;
      end
    endcase

    word_c.target_id   = tgt_n.id;
    word_c.target_addr = tgt_n.addr;
    word_c.target_port = tgt_n.port;
    word_c.succ_id     = suc_n.id;
    word_c.succ_addr   = suc_n.addr;
    word_c.succ_port   = suc_n.port;
    word_c.pred_id     = pre_n.id;
    word_c.pred_addr   = pre_n.addr;
    word_c.pred_port   = pre_n.port;
    if (pick == 3'b001 && dup_r) begin
      word_c.status = srin_pkg::STAT_DUP;
    end else if (pick == 3'b001 && full_r) begin
      word_c.status = srin_pkg::STAT_FULL;
    end else begin
      word_c.status = srin_pkg::STAT_INSERTED;
    end
    word_c.last = (pend & ~pick) == '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_word <= word_c;
    end
  end

`ifndef SYNTH
  // table never grows past its depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    node_count <= CW'(MAX_PEERS))
    else $error("node count exceeds table depth");

  // pending results only exist while emitting
  a_pend_emit: assert property (@(posedge clk) disable iff (rst)
    (pend != '0) |-> (state == ST_EMIT))
    else $error("results pending outside emit state");

  // an insert raises the count by exactly one
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    ins |=> (node_count == $past(node_count) + CW'(1)))
    else $error("node count did not follow insert");
`endif

endmodule

`default_nettype wire

FILE: sim/tb_sorted_ring_insert_neighbors.sv
// tb_sorted_ring_insert_neighbors: self-checking bench for the sorted ring neighbor table
// joins nodes, predicts every neighbor report in an in-bench table model, checks the out words
// depends on srin_pkg and sorted_ring_insert_neighbors
`timescale 1ns / 100ps

module tb_sorted_ring_insert_neighbors;

  localparam int PEERS         = 16;   // table depth of the instance
  localparam int ITEMS         = 470;  // join words offered over the whole run
  localparam int SETTLE_CYCLES = 8;    // idle time after the last owed report is taken
  localparam int QUIET_LIMIT   = 500;  // cycles without any handshake before giving up

  logic                          clk       = 1'b0;
  logic                          rst       = 1'b1;
  logic                          in_valid  = 1'b0;
  logic                          in_stall;
  srin_pkg::in_word_t            in_word   = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  srin_pkg::out_word_t           out_word;
  logic                          cfg_we    = 1'b0;
  logic [srin_pkg::ID_W-1:0]     cfg_data  = '0;

  // in-bench copy of the ring table and of the local node register
  srin_pkg::node_t               ring_table [PEERS];
  int                            ring_count = 0;
  logic [srin_pkg::ID_W-1:0]     local_id   = '0;

  // reports still owed by the block, oldest first
  srin_pkg::out_word_t           neighbor_reports [$];

  // bookkeeping for the closing summary and the verdict
  int                  joins_sent     = 0;
  int                  inserted_joins = 0;
  int                  dup_joins      = 0;
  int                  full_joins     = 0;
  int                  held_notices   = 0;
  int                  reports_seen   = 0;
  int                  mismatches     = 0;
  int                  stall_left     = 0;
  int                  quiet_cycles   = 0;
  bit                  calm           = 1'b0;  // no idling on either side while set

  sorted_ring_insert_neighbors #(
    .MAX_PEERS(PEERS)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // idle length drawn per word, zero in calm stretches and about a quarter of the time
  function automatic int pick_idle_cycles();
    if (calm || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 12);
  endfunction

  function automatic bit ring_has(input logic [srin_pkg::ID_W-1:0] id);
    int i;
    for (i = 0; i < ring_count; i++)
      if (ring_table[i].id == id) return 1'b1;
    return 1'b0;
  endfunction

  // node_t and the three node groups of out_word_t share one field order,
  // so a report is just three table entries, a status and the last flag
  function automatic srin_pkg::out_word_t node_report(input int t, input int s, input int p,
                                                      input logic fin);
    return srin_pkg::out_word_t'({ring_table[t], ring_table[s], ring_table[p],
                                  srin_pkg::STAT_INSERTED, fin});
  endfunction

  // apply one accepted join to the table copy and queue the reports it owes
  function automatic void join_node(input srin_pkg::in_word_t w);
    int i, pos, n, pi, si;
    logic tell_pred, tell_succ;
    joins_sent++;
    // a known id wins over a full table; either way the word is echoed, neighbors zero
    if (ring_has(w.new_id)) begin
      neighbor_reports.push_back(srin_pkg::out_word_t'({w, {(2 * srin_pkg::NODE_W){1'b0}},
                                                        srin_pkg::STAT_DUP, 1'b1}));
      dup_joins++;
      return;
    end
    if (ring_count >= PEERS) begin
      neighbor_reports.push_back(srin_pkg::out_word_t'({w, {(2 * srin_pkg::NODE_W){1'b0}},
                                                        srin_pkg::STAT_FULL, 1'b1}));
      full_joins++;
      return;
    end
    // sorted insert, larger entries move up one slot
    pos = 0;
    while (pos < ring_count && ring_table[pos].id < w.new_id) pos++;
    for (i = ring_count; i > pos; i--) ring_table[i] = ring_table[i - 1];
    ring_table[pos] = srin_pkg::node_t'(w);
    n = ring_count + 1;
    ring_count = n;
    inserted_joins++;
    // ring neighbors wrap at both ends; with two nodes both are the same entry
    si = (pos + 1) % n;
    pi = (pos + n - 1) % n;
    tell_pred = (n >= 2) && (ring_table[pi].id != local_id);
    tell_succ = (n >= 2) && (si != pi) && (ring_table[si].id != local_id);
    if (n >= 2 && !tell_pred) held_notices++;
    if (n >= 2 && si != pi && !tell_succ) held_notices++;
    neighbor_reports.push_back(node_report(pos, si, pi, !(tell_pred || tell_succ)));
    if (tell_pred)
      neighbor_reports.push_back(node_report(pi, pos, (pi + n - 1) % n, !tell_succ));
    if (tell_succ)
      neighbor_reports.push_back(node_report(si, (si + 1) % n, pos, 1'b1));
  endfunction

  function automatic srin_pkg::in_word_t random_join(input logic [srin_pkg::ID_W-1:0] id);
    return '{id, $urandom, 16'($urandom)};
  endfunction

  function automatic string report_text(input srin_pkg::out_word_t r);
    return $sformatf("tgt %0d/%h/%0d succ %0d/%h/%0d pred %0d/%h/%0d st %0d last %0d",
                     r.target_id, r.target_addr, r.target_port, r.succ_id, r.succ_addr,
                     r.succ_port, r.pred_id, r.pred_addr, r.pred_port, r.status, r.last);
  endfunction

  // offer one join word; valid stays up after acceptance so a back-to-back word
  // does not drop it, and whoever idles next lowers it
  task automatic offer_join(input srin_pkg::in_word_t w);
    int gap;
    gap = pick_idle_cycles();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_word  <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    join_node(w);
  endtask

  // sender holds off until every owed report has been taken, then lets the block settle
  task automatic wait_reports_done();
    in_valid <= 1'b0;
    while (neighbor_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // self_id only changes while the block is idle
  task automatic set_local_id(input logic [srin_pkg::ID_W-1:0] id);
    wait_reports_done();
    cfg_data <= id;
    cfg_we   <= 1'b1;
    @(posedge clk);
    cfg_we   <= 1'b0;
    local_id = id;
  endtask

  task automatic check_report(input srin_pkg::out_word_t got);
    srin_pkg::out_word_t want;
    logic [10:0]         diff;
    reports_seen++;
    if (neighbor_reports.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: report with nothing owed: %s", $time, report_text(got));
    end else begin
      want = neighbor_reports.pop_front();
      diff = {want.target_id != got.target_id, want.target_addr != got.target_addr,
              want.target_port != got.target_port, want.succ_id != got.succ_id,
              want.succ_addr != got.succ_addr, want.succ_port != got.succ_port,
              want.pred_id != got.pred_id, want.pred_addr != got.pred_addr,
              want.pred_port != got.pred_port, want.status != got.status,
              want.last != got.last};
      if (diff != '0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: report mismatch, field flags %b", $time, diff);
          $display("  expected %s", report_text(want));
          $display("  actual   %s", report_text(got));
        end
      end
    end
  endtask

  // out side: check each taken word, then draw how long to stall before the next one
  always @(posedge clk) begin
    if (rst) begin
      stall_left = 0;
    end else if (out_valid && !out_stall) begin
      check_report(out_word);
      stall_left = pick_idle_cycles();
      out_stall <= (stall_left > 0);
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= (stall_left > 0);
    end
  end

  // watchdog on handshake activity
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // lone node is its own successor and predecessor, then the same id again
  task automatic test_single_node();
    set_local_id('0);
    offer_join('{10'd1, 32'hC0A8_0001, 16'd8080});
    offer_join(random_join(10'd1));
  endtask

  // second node: the first one is notified once with the newcomer on both sides
  task automatic test_two_nodes();
    offer_join(random_join(10'd512));
  endtask

  // top end with all-ones fields (successor wraps to the lowest entry),
  // then bottom end with all-zero fields (predecessor wraps to the highest)
  task automatic test_ring_wrap();
    offer_join('{10'd1023, 32'hFFFF_FFFF, 16'hFFFF});
    offer_join('{10'd0, 32'h0000_0000, 16'h0000});
  endtask

  // notices addressed to the local node are dropped, the join report never is
  task automatic test_local_node_silenced();
    set_local_id(10'd1023);
    offer_join(random_join(10'd2));     // both neighbors told
    offer_join(random_join(10'd1022));  // successor is local, no notice
    set_local_id(10'd512);
    offer_join(random_join(10'd700));   // predecessor is local, successor told
    set_local_id(10'd300);
    offer_join(random_join(10'd300));   // the joining node is the local node
    offer_join(random_join(10'd0));     // lowest id again
    offer_join(random_join(10'd1023));  // highest id again
  endtask

  // random joins until the table fills, moving self_id around every few inserts
  task automatic test_random_fill();
    logic [srin_pkg::ID_W-1:0] id;
    int                        batch;
    batch = 0;
    while (ring_count < PEERS) begin
      if (batch == 3) begin
        batch = 0;
        if ($urandom_range(0, 1)) id = ring_table[$urandom_range(0, ring_count - 1)].id;
        else id = srin_pkg::ID_W'($urandom_range(0, 1023));
        set_local_id(id);
      end
      if ($urandom_range(0, 4) == 0) begin
        id = ring_table[$urandom_range(0, ring_count - 1)].id;
      end else begin
        do id = srin_pkg::ID_W'($urandom_range(0, 1023)); while (ring_has(id));
        batch++;
      end
      offer_join(random_join(id));
    end
  endtask

  // new id on a full table is turned away; a known id still reports as present
  task automatic test_full_table();
    logic [srin_pkg::ID_W-1:0] id;
    do id = srin_pkg::ID_W'($urandom_range(0, 1023)); while (ring_has(id));
    offer_join(random_join(id));
    offer_join(random_join(ring_table[PEERS - 1].id));
    offer_join(random_join(ring_table[0].id));
  endtask

  // mixed known and random ids against the full table, with calm stretches,
  // full drains and register writes along the way
  task automatic test_random_traffic(input int count);
    logic [srin_pkg::ID_W-1:0] id;
    int                        k;
    for (k = 0; k < count; k++) begin
      if (k % 40 == 0) calm = ($urandom_range(0, 3) == 0);
      if (k % 90 == 89) begin
        id = srin_pkg::ID_W'($urandom_range(0, 1023));
        set_local_id(id);
      end else if (k % 60 == 59) begin
        wait_reports_done();
      end
      if ($urandom_range(0, 1)) id = ring_table[$urandom_range(0, ring_count - 1)].id;
      else id = srin_pkg::ID_W'($urandom_range(0, 1023));
      offer_join(random_join(id));
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_single_node();
    test_two_nodes();
    test_ring_wrap();
    test_local_node_silenced();
    test_random_fill();
    test_full_table();
    test_random_traffic(ITEMS - joins_sent);
    wait_reports_done();
    $display("%0d joins: %0d inserted, %0d already present, %0d refused by a full table",
             joins_sent, inserted_joins, dup_joins, full_joins);
    $display("%0d reports checked, %0d notices to the local node held back, %0d mismatches",
             reports_seen, held_notices, mismatches);
    if (mismatches == 0 && neighbor_reports.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/srin_pkg.sv
hw/rtl/srin_cell.sv
hw/rtl/sorted_ring_insert_neighbors.sv
sim/tb_sorted_ring_insert_neighbors.sv
